// File: src/r2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_pkg
// Shared widths, constants and helpers for the matrix to Euler angle block.
// ----------------------------------------------------------------------------
package r2e_pkg;

  localparam int ElemW     = 16;
  localparam int TransW    = 32;
  localparam int ThrW      = 15;
  localparam int SqrtBits  = 15;            // cx in 0..16384
  localparam int RemW      = 30;            // 1 - m32^2 in Q2.28, saturated
  localparam int OpW       = 17;            // atan2 operand after sign flip
  localparam int XyW       = 36;            // CORDIC x/y with headroom
  localparam int ZW        = 34;            // angle accumulator, Q.29
  localparam int TableLen  = 24;
  localparam int DefCordicStages = 16;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(1);
  localparam logic signed [ZW-1:0] PiQ29 = ZW'(64'sd1686629713);
  localparam logic signed [14:0] HalfPiQ13 = 15'sd12868;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;

  typedef struct packed {
    logic signed [ElemW-1:0]  m11;
    logic signed [ElemW-1:0]  m12;
    logic signed [ElemW-1:0]  m22;
    logic signed [ElemW-1:0]  m31;
    logic signed [ElemW-1:0]  m32;
    logic signed [ElemW-1:0]  m33;
    logic signed [TransW-1:0] tx;
    logic signed [TransW-1:0] ty;
    logic signed [TransW-1:0] tz;
    logic                     lock;
    logic [2:0]               zero;    // atan2 with both operands zero
  } side_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  zero;
  } lane_t;

  function automatic logic signed [ZW-1:0] atan_q29(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(64'sd421657428);
      1:  v = ZW'(64'sd248918915);
      2:  v = ZW'(64'sd131521918);
      3:  v = ZW'(64'sd66762579);
      4:  v = ZW'(64'sd33510843);
      5:  v = ZW'(64'sd16771758);
      6:  v = ZW'(64'sd8387925);
      7:  v = ZW'(64'sd4194219);
      8:  v = ZW'(64'sd2097141);
      9:  v = ZW'(64'sd1048575);
      10: v = ZW'(64'sd524288);
      11: v = ZW'(64'sd262144);
      12: v = ZW'(64'sd131072);
      13: v = ZW'(64'sd65536);
      14: v = ZW'(64'sd32768);
      15: v = ZW'(64'sd16384);
      16: v = ZW'(64'sd8192);
      17: v = ZW'(64'sd4096);
      18: v = ZW'(64'sd2048);
      19: v = ZW'(64'sd1024);
      20: v = ZW'(64'sd512);
      21: v = ZW'(64'sd256);
      22: v = ZW'(64'sd128);
      23: v = ZW'(64'sd64);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Fold x into the right half plane and scale operands by 2^16.
  function automatic lane_t lane_prep(input logic signed [OpW-1:0] y,
                                      input logic signed [OpW-1:0] x);
    lane_t l;
    logic signed [OpW-1:0] yy;
    logic signed [OpW-1:0] xx;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.z = (y >= 0) ? PiQ29 : -PiQ29;
      xx  = -x;
      yy  = -y;
    end else begin
      l.z = '0;
      xx  = x;
      yy  = y;
    end
    l.x = {{(XyW-OpW-16){xx[OpW-1]}}, xx, 16'h0000};
    l.y = {{(XyW-OpW-16){yy[OpW-1]}}, yy, 16'h0000};
    return l;
  endfunction

  // Round Q.29 to Q3.13 and clamp to +-lim.
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [ZW-1:0] s;
    logic signed [ZW-17:0] a;
    logic signed [ZW-17:0] l;
    s = z + ZW'(32768);
    a = s[ZW-1:16];
    l = (ZW-16)'(lim);
    if (a > l) a = l;
    if (a < -l) a = -l;
    return a[15:0];
  endfunction

endpackage
`default_nettype wire

// File: src/r2e_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_in_if / r2e_out_if
// Valid/ready channels for transform items and angle results.
// ----------------------------------------------------------------------------
interface r2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m22;
  logic signed [15:0] m31;
  logic signed [15:0] m32;
  logic signed [15:0] m33;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;
  modport source (output valid, m11, m12, m22, m31, m32, m33, trans_x, trans_y,
                  trans_z, input ready);
  modport sink (input valid, m11, m12, m22, m31, m32, m33, trans_x, trans_y,
                trans_z, output ready);
endinterface

interface r2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic signed [31:0] pivot_x;
  logic signed [31:0] pivot_y;
  logic signed [31:0] pivot_z;
  logic               gimbal_lock;
  modport source (output valid, angle_x, angle_y, angle_z, pivot_x, pivot_y,
                  pivot_z, gimbal_lock, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, pivot_x, pivot_y,
                pivot_z, gimbal_lock, output ready);
endinterface
`default_nettype wire

// File: src/r2e_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_sqrt_cell
// One result bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module r2e_sqrt_cell
  import r2e_pkg::*;
#(
  parameter int BIT = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [RemW-1:0]     rem_i,
  input  wire logic [SqrtBits-1:0] res_i,
  output logic      [RemW-1:0]     rem_o,
  output logic      [SqrtBits-1:0] res_o
);

  logic [RemW:0] trial;
  logic          take;

  assign trial = ({1'b0, RemW'(res_i)} << (BIT + 1)) + ((RemW+1)'(1) << (2 * BIT));
  assign take  = {1'b0, rem_i} >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= take ? RemW'({1'b0, rem_i} - trial) : rem_i;
      res_o <= take ? (res_i | (SqrtBits'(1) << BIT)) : res_i;
    end
  end

endmodule
`default_nettype wire

// File: src/r2e_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2e_cordic_cell
// One vectoring CORDIC micro-rotation for a single atan2 lane, registered.
// ----------------------------------------------------------------------------
module r2e_cordic_cell
  import r2e_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire lane_t lane_i,
  output lane_t      lane_o
);

  logic signed [XyW-1:0] dx;
  logic signed [XyW-1:0] dy;
  lane_t                 nxt;

  assign dx = lane_i.y >>> STAGE;
  assign dy = lane_i.x >>> STAGE;

  always_comb begin
    nxt.zero = lane_i.zero;
    if (lane_i.y > 0) begin
      nxt.x = lane_i.x + dx;
      nxt.y = lane_i.y - dy;
      nxt.z = lane_i.z + atan_q29(STAGE);
    end else begin
      nxt.x = lane_i.x - dx;
      nxt.y = lane_i.y + dy;
      nxt.z = lane_i.z - atan_q29(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_o <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/rotation_matrix_to_euler_xyz.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_xyz
// Rotation matrix to XYZ Euler angles, pivot passed through.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries one transform per transaction (six Q1.14 rotation
//   elements and a Q16.16 translation). item_out returns one transaction per
//   input: three angles in Q3.13 (angle_x in Q2.13), the translation as pivot and the lock flag.
//   cfg_we/cfg_data write lock_threshold; write it only while the block is
//   empty.
// Timing:
//   One transaction per cycle while the output is not stalled. The pipeline
//   holds a register for m32^2, fifteen square-root cells (one bit each), an
//   operand select register, one CORDIC cell per stage, and the output register.
// Reset:
//   rst empties the pipeline and sets lock_threshold to 1.
// Stall:
//   The whole chain of cells advances together whenever the output register
//   is empty or being taken; while it holds an item and the receiver holds
//   ready low, every stage holds and item_in.ready drops.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_xyz
  import r2e_pkg::*;
#(
  parameter int CORDIC_STAGES = DefCordicStages
) (
  input  wire logic            clk,
  input  wire logic            rst,
  r2e_in_if.sink               item_in,
  r2e_out_if.source            item_out,
  input  wire logic            cfg_we,
  input  wire logic [ThrW-1:0] cfg_data
);

  localparam int NStg   = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
  localparam int PrepSt = SqrtBits + 1;           // operand select stage
  localparam int LastSt = PrepSt + NStg;          // last side-band stage
  localparam int Depth  = LastSt + 2;             // plus output register

  logic [ThrW-1:0] lock_threshold;
  logic            adv;
  logic [Depth-1:0] vld;

  side_t side [0:LastSt];
  side_t side_prep;

  logic [RemW-1:0]     rem_s [0:SqrtBits];
  logic [SqrtBits-1:0] res_s [0:SqrtBits];

  lane_t lane [0:2][0:NStg];
  lane_t lane_prep [0:2];

  logic signed [31:0] sq;
  logic signed [31:0] rem_full;

  // Advance the whole chain when the output slot is free.
  assign adv           = !item_out.valid || item_out.ready;
  assign item_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= ThrReset;
    end else if (cfg_we) begin
      lock_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], item_in.valid};
    end
  end

  // Stage 0: square m32 and form 1 - m32^2, saturated at zero.
  assign sq       = 32'(item_in.m32) * 32'(item_in.m32);
  assign rem_full = 32'sd268435456 - sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0]     <= (rem_full > 0) ? RemW'(rem_full) : '0;
      res_s[0]     <= '0;
      side[0].m11  <= item_in.m11;
      side[0].m12  <= item_in.m12;
      side[0].m22  <= item_in.m22;
      side[0].m31  <= item_in.m31;
      side[0].m32  <= item_in.m32;
      side[0].m33  <= item_in.m33;
      side[0].tx   <= item_in.trans_x;
      side[0].ty   <= item_in.trans_y;
      side[0].tz   <= item_in.trans_z;
      side[0].lock <= 1'b0;
      side[0].zero <= '0;
    end
  end

  // Square-root cells, most significant bit first.
  for (genvar k = 1; k <= SqrtBits; k++) begin : g_sqrt
    r2e_sqrt_cell #(.BIT(SqrtBits - k)) u_cell (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_s[k-1]),
      .res_i (res_s[k-1]),
      .rem_o (rem_s[k]),
      .res_o (res_s[k])
    );
  end

  // Operand select: lock test and fold of the three atan2 lanes.
  always_comb begin
    logic lk;
    lk = res_s[SqrtBits] < lock_threshold;
    side_prep      = side[PrepSt-1];
    side_prep.lock = lk;
    if (lk) begin
      lane_prep[0] = r2e_pkg::lane_prep('0, '0);
      lane_prep[1] = r2e_pkg::lane_prep(OpW'(side[PrepSt-1].m31),
                                        OpW'(side[PrepSt-1].m11));
      lane_prep[2] = r2e_pkg::lane_prep('0, '0);
    end else begin
      lane_prep[0] = r2e_pkg::lane_prep(OpW'(side[PrepSt-1].m32),
                                        OpW'({1'b0, res_s[SqrtBits]}));
      lane_prep[1] = r2e_pkg::lane_prep(-OpW'(side[PrepSt-1].m31),
                                        OpW'(side[PrepSt-1].m33));
      lane_prep[2] = r2e_pkg::lane_prep(-OpW'(side[PrepSt-1].m12),
                                        OpW'(side[PrepSt-1].m22));
    end
    side_prep.zero = {lane_prep[2].zero, lane_prep[1].zero, lane_prep[0].zero};
  end

  // Side-band shift line; the select stage replaces lock and zero flags.
  for (genvar k = 1; k <= LastSt; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side[k] <= (k == PrepSt) ? side_prep : side[k-1];
      end
    end
  end

  // CORDIC cells: three lanes side by side in every stage.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        lane[l][0] <= lane_prep[l];
      end
    end
    for (genvar s = 0; s < NStg; s++) begin : g_stage
      r2e_cordic_cell #(.STAGE(s)) u_cell (
        .clk    (clk),
        .en     (adv),
        .lane_i (lane[l][s]),
        .lane_o (lane[l][s+1])
      );
    end
  end

  // Output register: round, clamp and pick the lock branch.
  logic signed [15:0] ax_r;
  logic signed [15:0] ay_r;
  logic signed [15:0] az_r;

  assign ax_r = side[LastSt].zero[0] ? '0 : to_q13(lane[0][NStg].z, 16'(HalfPiQ13));
  assign ay_r = side[LastSt].zero[1] ? '0 : to_q13(lane[1][NStg].z, PiQ13);
  assign az_r = side[LastSt].zero[2] ? '0 : to_q13(lane[2][NStg].z, PiQ13);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side[LastSt].lock) begin
        item_out.angle_x <= (side[LastSt].m32 > 0) ? HalfPiQ13 : -HalfPiQ13;
        item_out.angle_z <= '0;
      end else begin
        item_out.angle_x <= ax_r[14:0];
        item_out.angle_z <= az_r;
      end
      item_out.angle_y     <= ay_r;
      item_out.pivot_x     <= side[LastSt].tx;
      item_out.pivot_y     <= side[LastSt].ty;
      item_out.pivot_z     <= side[LastSt].tz;
      item_out.gimbal_lock <= side[LastSt].lock;
    end
  end

  assign item_out.valid = vld[Depth-1];

  // Lock branch always reports zero z.
  a_lock_z: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && item_out.gimbal_lock |-> item_out.angle_z == '0)
    else $error("angle_z not zero under gimbal lock");

  // Lock branch x is exactly plus or minus pi/2.
  a_lock_x: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && item_out.gimbal_lock |->
      (item_out.angle_x == HalfPiQ13 || item_out.angle_x == -HalfPiQ13))
    else $error("angle_x not pi/2 under gimbal lock");

  // Angle y stays within +-pi after clamping.
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    item_out.valid |-> (item_out.angle_y <= PiQ13 && item_out.angle_y >= -PiQ13))
    else $error("angle_y out of range");

  // A stalled output freezes the pipeline input side.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && !item_out.ready |-> !item_in.ready)
    else $error("input accepted while output stalled");

endmodule
`default_nettype wire
